[rtl/core/dsdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsdf_pkg
// Shared widths, constants and segment tables of the decimal display formatter.
// ----------------------------------------------------------------------------
package dsdf_pkg;

    localparam int NUM_DIGITS_DEF = 6;

    localparam int VALUE_W = 20;
    localparam int POS_W   = 3;
    localparam int SEG_W   = 8;
    localparam int DP_W    = 3;
    localparam int DIGIT_W = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_DECIMAL_POINT = 1'b0;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 20-bit x
    localparam int PROD_W        = 40;
    localparam logic [PROD_W-1:0] RECIP10 = 40'd838861;
    localparam int RECIP10_SHIFT = 23;
    localparam int QUOT_PROD_W   = PROD_W - RECIP10_SHIFT;

    function automatic logic [SEG_W-1:0] seg_first(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDB;
            4'd3:    s = 8'hF3;
            4'd4:    s = 8'h67;
            4'd5:    s = 8'hB7;
            4'd6:    s = 8'hBF;
            4'd7:    s = 8'hE4;
            4'd8:    s = 8'hFF;
            4'd9:    s = 8'hF7;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [SEG_W-1:0] seg_second(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h28;
            4'd1:    s = 8'h20;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/core/dsdf_div_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsdf_div_stage
// One pipeline stage: divide by ten, store the remainder as one decimal digit
// and track the number of significant digits.
// ----------------------------------------------------------------------------
module dsdf_div_stage #(
    parameter int NUM_DIGITS = dsdf_pkg::NUM_DIGITS_DEF,
    parameter int STAGE      = 1
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        en,
    input  wire logic                                        valid_in,
    input  wire logic [dsdf_pkg::VALUE_W-1:0]                quot_in,
    input  wire logic [NUM_DIGITS*dsdf_pkg::DIGIT_W-1:0]     digits_in,
    input  wire logic [$clog2(NUM_DIGITS+1)-1:0]             count_in,
    output logic                                             valid_out,
    output logic [dsdf_pkg::VALUE_W-1:0]                     quot_out,
    output logic [NUM_DIGITS*dsdf_pkg::DIGIT_W-1:0]          digits_out,
    output logic [$clog2(NUM_DIGITS+1)-1:0]                  count_out
);
    import dsdf_pkg::*;

    localparam int KW = $clog2(NUM_DIGITS + 1);

    logic [PROD_W-1:0]              prod;
    logic [VALUE_W-1:0]             quot;
    logic [VALUE_W-1:0]             rem;
    logic [NUM_DIGITS*DIGIT_W-1:0]  digits_next;
    logic [KW-1:0]                  count_next;
    logic                           valid_reg;
    logic [VALUE_W-1:0]             quot_reg;
    logic [NUM_DIGITS*DIGIT_W-1:0]  digits_reg;
    logic [KW-1:0]                  count_reg;

    always_comb
    begin
        prod        = PROD_W'(quot_in) * RECIP10;
        quot        = VALUE_W'(prod[PROD_W-1:RECIP10_SHIFT]);
        rem         = quot_in - (quot << 3) - (quot << 1);
        digits_next = digits_in;
        digits_next[(STAGE-1)*DIGIT_W +: DIGIT_W] = rem[DIGIT_W-1:0];
        if ((STAGE < NUM_DIGITS) && (quot != '0))
        begin
            count_next = KW'(STAGE + 1);
        end
        else
        begin
            count_next = count_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg   <= quot;
            digits_reg <= digits_next;
            count_reg  <= count_next;
        end
    end

    assign valid_out  = valid_reg;
    assign quot_out   = quot_reg;
    assign digits_out = digits_reg;
    assign count_out  = count_reg;

endmodule
`default_nettype wire

[rtl/core/dsdf_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsdf_serializer
// Turns one converted request into position writes: blank positions from the
// top down, then digit positions from zero up, through a registered output.
// ----------------------------------------------------------------------------
module dsdf_serializer #(
    parameter int NUM_DIGITS = dsdf_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        load_valid,
    output logic                                             load_ready,
    input  wire logic [NUM_DIGITS*dsdf_pkg::DIGIT_W-1:0]     load_digits,
    input  wire logic [$clog2(NUM_DIGITS+1)-1:0]             load_count,
    input  wire logic                                        load_overflow,
    input  wire logic [dsdf_pkg::DP_W-1:0]                   decimal_point,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output logic [dsdf_pkg::POS_W-1:0]                       position,
    output logic [dsdf_pkg::SEG_W-1:0]                       segment_low,
    output logic [dsdf_pkg::SEG_W-1:0]                       segment_high,
    output logic                                             blank,
    output logic                                             overflow,
    output logic                                             last
);
    import dsdf_pkg::*;

    localparam int KW = $clog2(NUM_DIGITS + 1);

    logic                           busy_reg;
    logic [KW-1:0]                  step_reg;
    logic [KW-1:0]                  nblank_reg;
    logic [KW-1:0]                  dp_reg;
    logic                           ovf_reg;
    logic [NUM_DIGITS*DIGIT_W-1:0]  digits_reg;
    logic                           out_valid_reg;
    logic [POS_W-1:0]               position_reg;
    logic [SEG_W-1:0]               seg_low_reg;
    logic [SEG_W-1:0]               seg_high_reg;
    logic                           blank_reg;
    logic                           overflow_reg;
    logic                           last_reg;

    logic                           can_emit;
    logic                           emit;
    logic                           last_step;
    logic                           load;
    logic                           dp_ok;
    logic [KW-1:0]                  dp_next;
    logic [KW-1:0]                  ndig;
    logic [KW-1:0]                  nblank_next;
    logic                           in_blank;
    logic [KW-1:0]                  digit_pos;
    logic [DIGIT_W-1:0]             cur_digit;
    logic                           point;

    always_comb
    begin
        can_emit    = !out_valid_reg || !out_stall;
        emit        = busy_reg && can_emit;
        last_step   = (step_reg == KW'(NUM_DIGITS - 1));
        load_ready  = !busy_reg || (emit && last_step);
        load        = load_valid && load_ready;
        dp_ok       = int'(decimal_point) <= (NUM_DIGITS - 1);
        dp_next     = dp_ok ? KW'(decimal_point) : '0;
        ndig        = (dp_next >= load_count) ? (dp_next + KW'(1)) : load_count;
        nblank_next = KW'(NUM_DIGITS) - ndig;
        in_blank    = step_reg < nblank_reg;
        digit_pos   = step_reg - nblank_reg;
        cur_digit   = digits_reg[DIGIT_W-1:0];
        point       = (digit_pos == dp_reg) && (digit_pos != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_emit)
            begin
                out_valid_reg <= busy_reg;
            end
            if (load)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (emit)
            begin
                busy_reg <= !last_step;
                step_reg <= step_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nblank_reg <= nblank_next;
            dp_reg     <= dp_next;
            ovf_reg    <= load_overflow;
            digits_reg <= load_digits;
        end
        else if (emit && !in_blank)
        begin
            digits_reg <= digits_reg >> DIGIT_W;
        end
        if (emit)
        begin
            overflow_reg <= ovf_reg;
            last_reg     <= last_step;
            blank_reg    <= in_blank;
            if (in_blank)
            begin
                position_reg <= POS_W'(NUM_DIGITS - 1) - POS_W'(step_reg);
                seg_low_reg  <= '0;
                seg_high_reg <= '0;
            end
            else
            begin
                position_reg <= POS_W'(digit_pos);
                seg_low_reg  <= seg_first(cur_digit);
                seg_high_reg <= seg_second(cur_digit) | SEG_W'(point);
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = position_reg;
    assign segment_low  = seg_low_reg;
    assign segment_high = seg_high_reg;
    assign blank        = blank_reg;
    assign overflow     = overflow_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

[rtl/core/decimal_segment_display_formatter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_segment_display_formatter
// Path: a taken request passes the input register, one divide-by-ten stage per
//   digit and the serializer load to its first registered position write; the
//   rest follow one per cycle while out_stall is low.
// The single result channel carries one write per position, so the serializer
//   loads a new request only as it finishes the previous one.
// Reset: pipeline and output empty, decimal point register cleared to 0.
// ----------------------------------------------------------------------------
module decimal_segment_display_formatter #(
    parameter int NUM_DIGITS = dsdf_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dsdf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dsdf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dsdf_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [dsdf_pkg::VALUE_W-1:0]      value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [dsdf_pkg::POS_W-1:0]             position,
    output logic [dsdf_pkg::SEG_W-1:0]             segment_low,
    output logic [dsdf_pkg::SEG_W-1:0]             segment_high,
    output logic                                   blank,
    output logic                                   overflow,
    output logic                                   last
);
    import dsdf_pkg::*;

    localparam int KW = $clog2(NUM_DIGITS + 1);

    logic [DP_W-1:0]                dp_reg;
    logic                           cfg_write;
    logic                           pipe_en;
    logic                           ser_ready;
    logic                           in_valid_reg;
    logic [VALUE_W-1:0]             in_value_reg;

    logic                           stg_valid  [0:NUM_DIGITS];
    logic [VALUE_W-1:0]             stg_quot   [0:NUM_DIGITS];
    logic [NUM_DIGITS*DIGIT_W-1:0]  stg_digits [0:NUM_DIGITS];
    logic [KW-1:0]                  stg_count  [0:NUM_DIGITS];

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_DECIMAL_POINT) ? APB_DATA_W'(dp_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_DECIMAL_POINT))
        begin
            dp_reg <= pwdata[DP_W-1:0];
        end
    end

    // advance the whole pipeline unless its last stage is held
    assign pipe_en  = !stg_valid[NUM_DIGITS] || ser_ready;
    assign in_stall = !pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            in_value_reg <= value;
        end
    end

    assign stg_valid[0]  = in_valid_reg;
    assign stg_quot[0]   = in_value_reg;
    assign stg_digits[0] = '0;
    assign stg_count[0]  = KW'(1);

    for (genvar s = 1; s <= NUM_DIGITS; s++)
    begin : g_stage
        dsdf_div_stage #(
            .NUM_DIGITS (NUM_DIGITS),
            .STAGE      (s)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (pipe_en),
            .valid_in   (stg_valid[s-1]),
            .quot_in    (stg_quot[s-1]),
            .digits_in  (stg_digits[s-1]),
            .count_in   (stg_count[s-1]),
            .valid_out  (stg_valid[s]),
            .quot_out   (stg_quot[s]),
            .digits_out (stg_digits[s]),
            .count_out  (stg_count[s])
        );
    end

    dsdf_serializer #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (stg_valid[NUM_DIGITS]),
        .load_ready    (ser_ready),
        .load_digits   (stg_digits[NUM_DIGITS]),
        .load_count    (stg_count[NUM_DIGITS]),
        .load_overflow (stg_quot[NUM_DIGITS] != '0),
        .decimal_point (dp_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .segment_low   (segment_low),
        .segment_high  (segment_high),
        .blank         (blank),
        .overflow      (overflow),
        .last          (last)
    );

endmodule
`default_nettype wire

[tb/sv/dsdf_write_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdf_write_checker
// Watches the request, position-write and register channels of the decimal
// display formatter. Computes the six position writes of each accepted value
// and compares every accepted write against the oldest one still due.
// ----------------------------------------------------------------------------
module dsdf_write_checker
    import dsdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [VALUE_W-1:0]    value,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [POS_W-1:0]      position,
    input  logic [SEG_W-1:0]      segment_low,
    input  logic [SEG_W-1:0]      segment_high,
    input  logic                  blank,
    input  logic                  overflow,
    input  logic                  last,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [SEG_W-1:0] seg_lo;
        logic [SEG_W-1:0] seg_hi;
        logic             blank;
        logic             overflow;
        logic             last;
    } seg_write_t;

    localparam logic [SEG_W-1:0] GLYPH_LO [10] = '{
        8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE4, 8'hFF, 8'hF7
    };
    localparam logic [SEG_W-1:0] GLYPH_HI [10] = '{
        8'h28, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    seg_write_t       writes_due[$];
    logic [DP_W-1:0]  point_pos;
    seg_write_t       due;

    initial errors = 0;

    function automatic void predict_writes(input logic [VALUE_W-1:0] v);
        int unsigned limit;
        int unsigned shown;
        int unsigned t;
        int unsigned dp;
        int unsigned d;
        int          digits;
        int          k;
        logic        ovf;
        seg_write_t  w;
        limit = 10 ** NUM_DIGITS_DEF;
        ovf = (v >= limit);
        shown = v % limit;
        digits = 1;
        t = v;
        while (t >= 10 && digits < NUM_DIGITS_DEF) begin
            t = t / 10;
            digits++;
        end
        dp = point_pos;
        if (dp > NUM_DIGITS_DEF - 1)
            dp = 0;
        if (dp >= digits)
            digits = dp + 1;
        k = 0;
        for (int p = NUM_DIGITS_DEF - 1; p >= digits; p--) begin
            w = '{position: POS_W'(p), seg_lo: '0, seg_hi: '0, blank: 1'b1,
                  overflow: ovf, last: (k == NUM_DIGITS_DEF - 1)};
            writes_due.push_back(w);
            k++;
        end
        for (int p = 0; p < digits; p++) begin
            d = shown % 10;
            shown = shown / 10;
            w = '{position: POS_W'(p), seg_lo: GLYPH_LO[d], seg_hi: GLYPH_HI[d],
                  blank: 1'b0, overflow: ovf, last: (k == NUM_DIGITS_DEF - 1)};
            if (p != 0)
                w.seg_hi[0] = (p == dp);
            writes_due.push_back(w);
            k++;
        end
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            point_pos = '0;
            writes_due.delete();
            pending <= 0;
        end
        else begin
            if (psel && penable && pready && (paddr >> 2) == REG_DECIMAL_POINT) begin
                if (pwrite)
                    point_pos = pwdata[DP_W-1:0];
                else
                    check_field("prdata", {{(APB_DATA_W-DP_W){1'b0}}, point_pos}, prdata);
            end
            if (out_valid && !out_stall) begin
                if (writes_due.size() == 0) begin
                    $error("unexpected position write: position %0d, segment_low %0h",
                           position, segment_low);
                    errors++;
                end
                else begin
                    due = writes_due.pop_front();
                    check_field("position", due.position, position);
                    check_field("segment_low", due.seg_lo, segment_low);
                    check_field("segment_high", due.seg_hi, segment_high);
                    check_field("blank", due.blank, blank);
                    check_field("overflow", due.overflow, overflow);
                    check_field("last", due.last, last);
                end
            end
            if (in_valid && !in_stall)
                predict_writes(value);
            pending <= writes_due.size();
        end
    end

endmodule

[tb/sv/tb_decimal_segment_display_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_segment_display_formatter
// Drives values and decimal point settings into the display formatter under
// varying sender gaps and receiver stalls; a checker beside the block
// predicts and compares every position write.
// ----------------------------------------------------------------------------
module tb_decimal_segment_display_formatter;
    import dsdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 120;
    localparam int PHASE_ITEMS    = 19;
    localparam int REG_SPARE      = 1;
    localparam logic [APB_ADDR_W-1:0] ADDR_POINT = APB_ADDR_W'(4 * REG_DECIMAL_POINT);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'(4 * REG_SPARE);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [VALUE_W-1:0]    value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [POS_W-1:0]      position;
    logic [SEG_W-1:0]      segment_low;
    logic [SEG_W-1:0]      segment_high;
    logic                  blank;
    logic                  overflow;
    logic                  last;

    int errors;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    decimal_segment_display_formatter dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .position(position),
        .segment_low(segment_low), .segment_high(segment_high), .blank(blank),
        .overflow(overflow), .last(last)
    );

    dsdf_write_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .position(position),
        .segment_low(segment_low), .segment_high(segment_high), .blank(blank),
        .overflow(overflow), .last(last),
        .errors(errors), .pending(pending)
    );

    // hold off for a long stretch on request, else stall at random
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_point(input int dp);
        apb_access(1'b1, ADDR_POINT, dp);
        apb_access(1'b0, ADDR_POINT, '0);
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            value    <= VALUE_W'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (NUM_DIGITS_DEF + 4) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        int unsigned n;
        int unsigned lo;
        sel = $urandom_range(9);
        if (sel < 6) begin
            n  = $urandom_range(NUM_DIGITS_DEF, 1);
            lo = (n == 1) ? 0 : 10 ** (n - 1);
            return VALUE_W'($urandom_range(10 ** n - 1, lo));
        end
        else if (sel < 8)
            return VALUE_W'($urandom_range(2 ** VALUE_W - 1, 10 ** NUM_DIGITS_DEF));
        else
            return VALUE_W'($urandom);
    endfunction

    initial begin
        int dp_plan [8] = '{3, 5, 7, 1, 6, 2, 4, 0};
        int first_values [13] = '{0, 1, 9, 10, 99, 100, 12345, 99999, 100000,
                                  999999, 1000000, 1000009, 1048575};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_point(0);
        foreach (first_values[i])
            send_value(first_values[i]);
        wait_drained();
        apb_access(1'b1, ADDR_SPARE, 5);
        send_value(4321);
        wait_drained();
        set_point(5);
        send_value(0);
        send_value(7);
        send_value(999999);
        wait_drained();
        set_point(7);
        send_value(42);
        wait_drained();
        set_point(1);
        send_value(0);
        send_value(3);
        wait_drained();
        set_point(6);
        send_value(8);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            set_point(dp_plan[ph]);
            idle_pct  = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 32 : 0;
            stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 32 : 0;
            if (ph == 4) begin
                idle_pct  = 0;
                stall_pct = 0;
                hold_req++;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    wait_drained();
                send_value(pick_value());
            end
            wait_drained();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
